@@ design/raccel_pkg.sv @@
// Package for the rotary encoder decoder with step acceleration.
// Holds payload structs, code constants, the quadrature transition ROM and
// the step saturation helper. No dependencies.
package raccel_pkg;

   // Request word: one encoder tick or one apply command
   typedef struct packed {
      logic       func;
      logic [1:0] encoder_pins;
      logic [7:0] value;
      logic [7:0] upper_limit;
      logic [7:0] lower_limit;
   } req_payload_type;

   // Response word: one per request
   typedef struct packed {
      logic [7:0]        new_value;
      logic              changed;
      logic signed [7:0] step_count;
   } rsp_payload_type;

   // Request function codes
   localparam logic FUNC_TICK  = 1'b0;
   localparam logic FUNC_APPLY = 1'b1;

   // Step codes from the transition ROM, also used as the direction memory
   localparam logic [1:0] DIR_NONE = 2'd0;
   localparam logic [1:0] DIR_UP   = 2'd1;
   localparam logic [1:0] DIR_DOWN = 2'd2;

   // Control register indexes
   localparam logic [7:0] CSR_STEP_LIMIT      = 8'd0;
   localparam logic [7:0] CSR_ACCEL_INCREMENT = 8'd1;
   localparam logic [7:0] CSR_ACCEL_SHIFT     = 8'd2;
   localparam logic [7:0] CSR_DECAY_RELOAD    = 8'd3;

   // Control register reset values
   localparam logic [6:0] STEP_LIMIT_RESET      = 7'd100;
   localparam logic [7:0] ACCEL_INCREMENT_RESET = 8'd3;
   localparam logic [2:0] ACCEL_SHIFT_RESET     = 3'd1;
   localparam logic [7:0] DECAY_RELOAD_RESET    = 8'd175;

   localparam logic [7:0] ACCEL_MAX = 8'hFF;

   // Transition ROM: index {state, pins}; entry {next_state[2:0], code[1:0]}.
   // State 7 is unreachable and falls back to state 0 with no step.
   function automatic logic [4:0] quad_rom(input logic [4:0] idx);
      logic [4:0] entry;
      unique case (idx)
         5'd0:    entry = 5'h03;
         5'd1:    entry = 5'h07;
         5'd2:    entry = 5'h13;
         5'd3:    entry = 5'h03;
         5'd4:    entry = 5'h0B;
         5'd5:    entry = 5'h07;
         5'd6:    entry = 5'h03;
         5'd7:    entry = 5'h03;
         5'd8:    entry = 5'h0B;
         5'd9:    entry = 5'h07;
         5'd10:   entry = 5'h0F;
         5'd11:   entry = 5'h03;
         5'd12:   entry = 5'h0B;
         5'd13:   entry = 5'h03;
         5'd14:   entry = 5'h0F;
         5'd15:   entry = 5'h01;
         5'd16:   entry = 5'h17;
         5'd17:   entry = 5'h03;
         5'd18:   entry = 5'h13;
         5'd19:   entry = 5'h03;
         5'd20:   entry = 5'h17;
         5'd21:   entry = 5'h1B;
         5'd22:   entry = 5'h13;
         5'd23:   entry = 5'h03;
         5'd24:   entry = 5'h17;
         5'd25:   entry = 5'h1B;
         5'd26:   entry = 5'h03;
         5'd27:   entry = 5'h02;
         default: entry = 5'h03;
      endcase
      return entry;
   endfunction

   // Clamp a 10-bit signed sum to the signed 8-bit range
   function automatic logic [7:0] sat8(input logic signed [9:0] v);
      logic [7:0] r;
      if (v > 10'sd127) begin
         r = 8'h7F;
      end else if (v < -10'sd128) begin
         r = 8'h80;
      end else begin
         r = v[7:0];
      end
      return r;
   endfunction

endpackage

@@ design/rotary_encoder_accel_decoder_core.sv @@
// Top level of the rotary encoder decoder with step acceleration.
// Depends on raccel_pkg for payload types, codes and the transition ROM.
//
// Accepts one request word per clock while the response side is not stalled,
// and returns one response word for each. A word first lands in an input
// register; the decode, acceleration and apply logic then updates the encoder
// state and fills the response register together, so the state loop closes
// every clock and sustains one word per cycle when the response side is not stalled.
// Control registers are written through the csr port (always ready) and must
// only change while no request is in flight.
module rotary_encoder_accel_decoder_core
   import raccel_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   // request channel
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   // response channel
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload,
   // control register writes
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [7:0]      csr_index,
   input  logic [7:0]      csr_wdata
);

   // control registers
   logic [6:0] step_limit_ff;
   logic [7:0] accel_increment_ff;
   logic [2:0] accel_shift_ff;
   logic [7:0] decay_reload_ff;

   // input and output stage
   logic            in_valid_ff;
   req_payload_type in_data_ff;
   logic            out_valid_ff;
   rsp_payload_type out_data_ff;
   rsp_payload_type out_data_in;
   logic            advance;

   // decoder state
   logic [2:0] quad_state_ff, quad_state_in;
   logic [1:0] last_dir_ff, last_dir_in;
   logic [7:0] accel_ff, accel_in;
   logic [7:0] decay_ff, decay_in;
   logic [7:0] accum_ff, accum_in;

   assign csr_ready   = 1'b1;
   assign advance     = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready   = !in_valid_ff || advance;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

   // control register writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         step_limit_ff      <= STEP_LIMIT_RESET;
         accel_increment_ff <= ACCEL_INCREMENT_RESET;
         accel_shift_ff     <= ACCEL_SHIFT_RESET;
         decay_reload_ff    <= DECAY_RELOAD_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_STEP_LIMIT)      step_limit_ff      <= csr_wdata[6:0];
         if (csr_index == CSR_ACCEL_INCREMENT) accel_increment_ff <= csr_wdata;
         if (csr_index == CSR_ACCEL_SHIFT)     accel_shift_ff     <= csr_wdata[2:0];
         if (csr_index == CSR_DECAY_RELOAD)    decay_reload_ff    <= csr_wdata;
      end
   end

   // decode, acceleration and apply for the word in the input register
   always_comb begin
      logic [4:0]        entry;
      logic [1:0]        code;
      logic signed [9:0] steps;
      logic signed [9:0] limit;
      logic [8:0]        accel_sum;
      logic [7:0]        accel_bumped;
      logic [7:0]        accel_shifted;
      logic [6:0]        extra;
      logic signed [9:0] apply_sum;

      entry         = quad_rom({quad_state_ff, in_data_ff.encoder_pins});
      code          = entry[1:0];
      steps         = {{2{accum_ff[7]}}, accum_ff};
      limit         = $signed({3'b000, step_limit_ff});
      accel_sum     = {1'b0, accel_ff} + {1'b0, accel_increment_ff};
      accel_bumped  = (accel_ff == ACCEL_MAX) ? ACCEL_MAX :
                      (accel_sum[8] ? ACCEL_MAX : accel_sum[7:0]);
      accel_shifted = accel_bumped >> accel_shift_ff;
      extra         = accel_shifted[6:0];
      apply_sum     = steps + $signed({2'b00, in_data_ff.value});

      quad_state_in = quad_state_ff;
      last_dir_in   = last_dir_ff;
      accel_in      = accel_ff;
      decay_in      = decay_ff;
      accum_in      = accum_ff;

      out_data_in.new_value = in_data_ff.value;
      out_data_in.changed   = 1'b0;

      if (in_data_ff.func == FUNC_TICK) begin
         quad_state_in = entry[4:2];
         priority if (code == DIR_UP) begin
            if (last_dir_ff == DIR_UP && steps < limit) begin
               accel_in = accel_bumped;
               accum_in = sat8(steps + 10'sd1 + $signed({3'b000, extra}));
            end else begin
               accum_in    = 8'h01;
               last_dir_in = DIR_UP;
               accel_in    = '0;
            end
         end else if (code == DIR_DOWN) begin
            if (last_dir_ff == DIR_DOWN && steps > -limit) begin
               accel_in = accel_bumped;
               accum_in = sat8(steps - 10'sd1 - $signed({3'b000, extra}));
            end else begin
               accum_in    = 8'hFF;
               last_dir_in = DIR_DOWN;
               accel_in    = '0;
            end
         end else if (decay_ff != '0) begin
            decay_in = decay_ff - 8'd1;
         end else begin
            // idle interval elapsed: reload and bleed off acceleration
            decay_in = decay_reload_ff;
            if (accel_ff != '0) accel_in = accel_ff - 8'd1;
         end
      end else if (accum_ff != '0) begin
         // apply: add steps, clamp with the upper bound tested first
         accum_in            = '0;
         out_data_in.changed = 1'b1;
         priority if (apply_sum > $signed({2'b00, in_data_ff.upper_limit})) begin
            out_data_in.new_value = in_data_ff.upper_limit;
         end else if (apply_sum < $signed({2'b00, in_data_ff.lower_limit})) begin
            out_data_in.new_value = in_data_ff.lower_limit;
         end else begin
            out_data_in.new_value = apply_sum[7:0];
         end
      end

      out_data_in.step_count = $signed(accum_in);
   end

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_payload;
      end
   end

   // output stage and state update
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         quad_state_ff <= '0;
         last_dir_ff   <= DIR_NONE;
         accel_ff      <= '0;
         decay_ff      <= '0;
         accum_ff      <= '0;
      end else begin
         if (advance) begin
            out_valid_ff  <= 1'b1;
            quad_state_ff <= quad_state_in;
            last_dir_ff   <= last_dir_in;
            accel_ff      <= accel_in;
            decay_ff      <= decay_in;
            accum_ff      <= accum_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule
